@@ rtl/mbrtu_pkg.sv @@
`default_nettype none

package mbrtu_pkg;

    localparam int unsigned MAX_REGS_DEF = 16;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned REG_IDX_W  = 4;
    localparam int unsigned LIVE_W     = 5;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned FRAME_LEN  = 7;
    localparam int unsigned FRAME_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIVE_COUNT = 1'd1;

    localparam logic OP_RX_BYTE  = 1'b0;
    localparam logic OP_REG_WRITE = 1'b1;

    localparam logic [BYTE_W-1:0] FUNC_READ_INPUT  = 8'h04;
    localparam logic [BYTE_W-1:0] EXC_FLAG         = 8'h80;
    localparam logic [BYTE_W-1:0] EXC_ILLEGAL_ADDR = 8'h02;
    localparam logic [BYTE_W-1:0] START_HIGH_REQ   = 8'h01;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_ADDR,
        RX_BODY
    } rx_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK,
        ST_HEAD,
        ST_RD,
        ST_HI,
        ST_LO,
        ST_CRCLO,
        ST_CRCHI
    } state_t;

    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] acc;
        acc = crc ^ {8'd0, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mbrtu_if.sv @@
`default_nettype none

interface mbrtu_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   opcode;
    logic [mbrtu_pkg::BYTE_W-1:0]           rx_byte;
    logic                                   after_silence;
    logic [mbrtu_pkg::REG_IDX_W-1:0]        reg_index;
    logic [mbrtu_pkg::WORD_W-1:0]           reg_value;

    modport source (output valid, opcode, rx_byte, after_silence, reg_index, reg_value,
                    input ready);
    modport sink (input valid, opcode, rx_byte, after_silence, reg_index, reg_value,
                  output ready);
endinterface

interface mbrtu_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [mbrtu_pkg::BYTE_W-1:0]           tx_byte;
    logic                                   frame_end;

    modport source (output valid, tx_byte, frame_end, input ready);
    modport sink (input valid, tx_byte, frame_end, output ready);
endinterface

interface mbrtu_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [mbrtu_pkg::CFG_IDX_W-1:0]        index;
    logic [mbrtu_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/modbus_rtu_read_input_slave.sv @@
// Modbus RTU slave, function 0x04 (Read Input Registers) only.
// req: one request per cycle at most. opcode 0 carries a received byte and
//   its silent-gap flag; opcode 1 writes one live register value.
// rsp: the reply bytes in order, frame_end high on the final CRC byte.
// cfg: index 0 writes the station address, index 1 the live register count.
// req is taken only while no reply is being built. The eighth byte of a
// frame starts the reply: a CRC check at one byte per cycle, a request
// check, then, while rsp is not stalled, one reply byte per cycle for
// the header and CRC, and a memory read and two bytes per register value.
// A failed request check gives an exception reply; a frame that fails
// the CRC check is dropped.
// rsp has an output register: a stalled receiver holds the current byte
// and pauses reply generation; the block takes new requests after the last
// byte is loaded even if it is not yet taken.
// Reset clears the receiver, sets the address to 1 and the live count to 0,
// and marks every live register as zero.
`default_nettype none

module modbus_rtu_read_input_slave #(
    parameter int unsigned MAX_REGS = mbrtu_pkg::MAX_REGS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    mbrtu_req_if.sink    req,
    mbrtu_rsp_if.source  rsp,
    mbrtu_cfg_if.sink    cfg
);

    localparam int unsigned IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_REGS + 1);

    mbrtu_pkg::state_t                      state_reg, state_next;
    mbrtu_pkg::rx_phase_t                   rx_phase_reg, rx_phase_next;
    logic [mbrtu_pkg::FRAME_IDX_W-1:0]      rx_idx_reg, rx_idx_next;
    logic [mbrtu_pkg::FRAME_IDX_W-1:0]      seq_cnt_reg, seq_cnt_next;
    logic [mbrtu_pkg::BYTE_W-1:0]           slave_addr_reg;
    logic [mbrtu_pkg::LIVE_W-1:0]           live_cnt_reg;
    logic [MAX_REGS-1:0]                    vld_reg;
    logic                                   tx_vld_reg, tx_vld_next;

    logic [mbrtu_pkg::BYTE_W-1:0]           frame_reg [mbrtu_pkg::FRAME_LEN];
    logic [mbrtu_pkg::WORD_W-1:0]           crc_reg, crc_next;
    logic [mbrtu_pkg::BYTE_W-1:0]           tx_byte_reg, tx_byte_next;
    logic                                   tx_last_reg, tx_last_next;
    logic                                   exc_reg, exc_next;
    logic [IDX_W-1:0]                       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                       rem_reg, rem_next;

    logic [mbrtu_pkg::WORD_W-1:0]           mem [MAX_REGS];
    logic [mbrtu_pkg::WORD_W-1:0]           rd_data_reg;
    logic                                   rd_vld_reg;
    logic [mbrtu_pkg::WORD_W-1:0]           rd_word;

    logic                                   req_acc;
    logic                                   cfg_acc;
    logic                                   mem_we;
    logic [IDX_W-1:0]                       mem_waddr;
    logic                                   mem_re;
    logic                                   frame_we;
    logic [mbrtu_pkg::FRAME_IDX_W-1:0]      frame_waddr;
    logic                                   load_ok;
    logic                                   emit;
    logic [mbrtu_pkg::BYTE_W-1:0]           emit_byte;
    logic                                   emit_last;
    logic                                   emit_crc;
    logic [mbrtu_pkg::LIVE_W-1:0]           live_clamp;
    logic [mbrtu_pkg::BYTE_W:0]             req_end;
    logic                                   req_ok;

    assign req.ready = (state_reg == mbrtu_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_acc   = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;

    assign rsp.valid     = tx_vld_reg;
    assign rsp.tx_byte   = tx_byte_reg;
    assign rsp.frame_end = tx_last_reg;

    assign load_ok = !tx_vld_reg || rsp.ready;
    assign rd_word = rd_vld_reg ? rd_data_reg : '0;

    assign mem_we    = req_acc && (req.opcode == mbrtu_pkg::OP_REG_WRITE) &&
                       (6'(req.reg_index) < 6'(MAX_REGS));
    assign mem_waddr = IDX_W'(req.reg_index);
    assign mem_re    = (state_reg == mbrtu_pkg::ST_RD);

    assign live_clamp = (6'(live_cnt_reg) > 6'(MAX_REGS)) ? mbrtu_pkg::LIVE_W'(MAX_REGS)
                                                          : live_cnt_reg;
    assign req_end = {1'b0, frame_reg[2]} + {1'b0, frame_reg[4]};
    assign req_ok  = (frame_reg[1] == mbrtu_pkg::START_HIGH_REQ) &&
                     (frame_reg[3] == 8'd0) &&
                     (frame_reg[2] < 8'(live_clamp)) &&
                     (frame_reg[4] != 8'd0) &&
                     (req_end <= 9'(live_clamp));

    always_comb
    begin
        state_next    = state_reg;
        rx_phase_next = rx_phase_reg;
        rx_idx_next   = rx_idx_reg;
        seq_cnt_next  = seq_cnt_reg;
        crc_next      = crc_reg;
        exc_next      = exc_reg;
        rd_ptr_next   = rd_ptr_reg;
        rem_next      = rem_reg;
        frame_we      = 1'b0;
        frame_waddr   = rx_idx_reg;
        emit          = 1'b0;
        emit_byte     = '0;
        emit_last     = 1'b0;
        emit_crc      = 1'b1;

        unique case (state_reg)
            mbrtu_pkg::ST_IDLE:
            begin
                if (req_acc && req.opcode == mbrtu_pkg::OP_RX_BYTE) begin
                    if (req.after_silence) begin
                        rx_phase_next = (req.rx_byte == slave_addr_reg) ? mbrtu_pkg::RX_ADDR
                                                                        : mbrtu_pkg::RX_IDLE;
                    end else if (rx_phase_reg == mbrtu_pkg::RX_ADDR) begin
                        if (req.rx_byte == mbrtu_pkg::FUNC_READ_INPUT) begin
                            rx_phase_next = mbrtu_pkg::RX_BODY;
                            frame_we      = 1'b1;
                            frame_waddr   = '0;
                            rx_idx_next   = 3'd1;
                        end else begin
                            rx_phase_next = mbrtu_pkg::RX_IDLE;
                        end
                    end else if (rx_phase_reg == mbrtu_pkg::RX_BODY) begin
                        frame_we    = 1'b1;
                        rx_idx_next = rx_idx_reg + 3'd1;
                        if (rx_idx_reg == 3'(mbrtu_pkg::FRAME_LEN - 1)) begin
                            rx_phase_next = mbrtu_pkg::RX_IDLE;
                            rx_idx_next   = '0;
                            state_next    = mbrtu_pkg::ST_CRC;
                            seq_cnt_next  = '0;
                            crc_next      = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT,
                                                                slave_addr_reg);
                        end
                    end
                end
            end
            mbrtu_pkg::ST_CRC:
            begin
                crc_next     = mbrtu_pkg::crc_byte(crc_reg, frame_reg[seq_cnt_reg]);
                seq_cnt_next = seq_cnt_reg + 3'd1;
                if (seq_cnt_reg == 3'(mbrtu_pkg::FRAME_LEN - 3))
                    state_next = mbrtu_pkg::ST_CHECK;
            end
            mbrtu_pkg::ST_CHECK:
            begin
                if (frame_reg[5] != crc_reg[7:0] || frame_reg[6] != crc_reg[15:8]) begin
                    state_next = mbrtu_pkg::ST_IDLE;
                end else begin
                    state_next   = mbrtu_pkg::ST_HEAD;
                    crc_next     = mbrtu_pkg::CRC_INIT;
                    seq_cnt_next = '0;
                    exc_next     = !req_ok;
                    rd_ptr_next  = IDX_W'(frame_reg[2]);
                    rem_next     = CNT_W'(frame_reg[4]);
                end
            end
            mbrtu_pkg::ST_HEAD:
            begin
                emit = load_ok;
                case (seq_cnt_reg)
                    3'd0:    emit_byte = slave_addr_reg;
                    3'd1:    emit_byte = exc_reg ? (mbrtu_pkg::FUNC_READ_INPUT |
                                                    mbrtu_pkg::EXC_FLAG)
                                                 : mbrtu_pkg::FUNC_READ_INPUT;
                    default: emit_byte = exc_reg ? mbrtu_pkg::EXC_ILLEGAL_ADDR
                                                 : {frame_reg[4][6:0], 1'b0};
                endcase
                if (load_ok) begin
                    seq_cnt_next = seq_cnt_reg + 3'd1;
                    if (seq_cnt_reg == 3'd2)
                        state_next = exc_reg ? mbrtu_pkg::ST_CRCLO : mbrtu_pkg::ST_RD;
                end
            end
            mbrtu_pkg::ST_RD:
            begin
                state_next = mbrtu_pkg::ST_HI;
            end
            mbrtu_pkg::ST_HI:
            begin
                emit      = load_ok;
                emit_byte = rd_word[15:8];
                if (load_ok)
                    state_next = mbrtu_pkg::ST_LO;
            end
            mbrtu_pkg::ST_LO:
            begin
                emit      = load_ok;
                emit_byte = rd_word[7:0];
                if (load_ok) begin
                    rd_ptr_next = rd_ptr_reg + IDX_W'(1);
                    rem_next    = rem_reg - CNT_W'(1);
                    state_next  = (rem_reg == CNT_W'(1)) ? mbrtu_pkg::ST_CRCLO
                                                         : mbrtu_pkg::ST_RD;
                end
            end
            mbrtu_pkg::ST_CRCLO:
            begin
                emit      = load_ok;
                emit_crc  = 1'b0;
                emit_byte = crc_reg[7:0];
                if (load_ok)
                    state_next = mbrtu_pkg::ST_CRCHI;
            end
            mbrtu_pkg::ST_CRCHI:
            begin
                emit      = load_ok;
                emit_crc  = 1'b0;
                emit_last = 1'b1;
                emit_byte = crc_reg[15:8];
                if (load_ok)
                    state_next = mbrtu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mbrtu_pkg::ST_IDLE;
            end
        endcase

        if (emit && emit_crc)
            crc_next = mbrtu_pkg::crc_byte(crc_reg, emit_byte);
    end

    always_comb
    begin
        tx_vld_next  = tx_vld_reg;
        tx_byte_next = tx_byte_reg;
        tx_last_next = tx_last_reg;
        if (emit) begin
            tx_vld_next  = 1'b1;
            tx_byte_next = emit_byte;
            tx_last_next = emit_last;
        end else if (rsp.ready) begin
            tx_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= mbrtu_pkg::ST_IDLE;
            rx_phase_reg   <= mbrtu_pkg::RX_IDLE;
            rx_idx_reg     <= '0;
            seq_cnt_reg    <= '0;
            slave_addr_reg <= 8'd1;
            live_cnt_reg   <= '0;
            vld_reg        <= '0;
            tx_vld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rx_phase_reg <= rx_phase_next;
            rx_idx_reg   <= rx_idx_next;
            seq_cnt_reg  <= seq_cnt_next;
            tx_vld_reg   <= tx_vld_next;
            if (mem_we)
                vld_reg[mem_waddr] <= 1'b1;
            if (cfg_acc) begin
                unique case (cfg.index)
                    mbrtu_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg.data;
                    mbrtu_pkg::CFG_LIVE_COUNT:
                        live_cnt_reg <= cfg.data[mbrtu_pkg::LIVE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        exc_reg     <= exc_next;
        rd_ptr_reg  <= rd_ptr_next;
        rem_reg     <= rem_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
        if (frame_we)
            frame_reg[frame_waddr] <= req.rx_byte;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= req.reg_value;
        if (mem_re) begin
            rd_data_reg <= mem[rd_ptr_reg];
            rd_vld_reg  <= vld_reg[rd_ptr_reg];
        end
    end

    a_hi_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbrtu_pkg::ST_HI |->
            $past(state_reg) == mbrtu_pkg::ST_RD || $past(state_reg) == mbrtu_pkg::ST_HI)
        else $error("register byte sent without a memory read");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbrtu_pkg::ST_RD |-> rem_reg != '0)
        else $error("register read with no registers left");

    a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        emit && state_reg == mbrtu_pkg::ST_CRCHI |=> rsp.valid && rsp.frame_end)
        else $error("final CRC byte not marked");

    a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbrtu_pkg::ST_CRC |-> $past(state_reg) == mbrtu_pkg::ST_IDLE ||
                                           $past(state_reg) == mbrtu_pkg::ST_CRC)
        else $error("CRC check entered from a busy state");

endmodule

`default_nettype wire
